// ===== sv/ialloc_pkg.sv =====
package ialloc_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
	localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic [1:0] REG_START_FILLED = 2'd0;
	localparam logic [1:0] REG_RANGE_LOW    = 2'd1;
	localparam logic [1:0] REG_RANGE_HIGH   = 2'd2;

	typedef enum logic [1:0] {
		CMD_TAKE_LOW = 2'd0,
		CMD_TAKE_ID  = 2'd1,
		CMD_GIVE     = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NOT_FREE     = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC
	} state_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_REMOVE,
		SH_INSERT
	} shift_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic exec;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_stop;
	} stat_t;

endpackage

// ===== sv/ialloc_ctrl.sv =====
module ialloc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ialloc_pkg::stat_t st,
	output ialloc_pkg::ctrl_t ctl,
	output logic             busy
);
	import ialloc_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_SCAN;
			S_SCAN: if (!st.need_scan || st.scan_stop) state_d = S_EXEC;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			S_SCAN: ctl.scan = st.need_scan;
			S_EXEC: ctl.exec = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/ialloc_dp.sv =====
module ialloc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ialloc_pkg::ctrl_t ctl,
	output ialloc_pkg::stat_t st,
	input  logic [1:0]        command,
	input  logic [31:0]       id_value,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              done,
	output logic [31:0]       id_out,
	output logic [1:0]        status
);
	import ialloc_pkg::*;

	// configuration
	logic        start_filled_q;
	logic [31:0] range_low_q, range_high_q;
	logic        sf_n;
	logic [31:0] rl_n, rh_n;

	// interval table
	logic [31:0] lo_q [MAX_INTERVALS];
	logic [31:0] hi_q [MAX_INTERVALS];
	logic [31:0] lo_d [MAX_INTERVALS];
	logic [31:0] hi_d [MAX_INTERVALS];
	logic [CNT_W-1:0] count_q, count_d;

	// request and scan state
	logic [1:0]       cmd_q;
	logic [31:0]      id_q;
	logic [CNT_W-1:0] pos_q;
	logic [31:0]      prev_lo_q, prev_hi_q, cur_lo_q, cur_hi_q;
	logic [31:0]      rd_lo, rd_hi;
	logic             at_end;
	logic             need_scan, scan_stop;

	// exec decisions
	shift_t           sh_mode;
	logic [IDX_W-1:0] sh_k, wl_k, wh_k, j_idx, p_idx;
	logic [31:0]      ins_lo, ins_hi, wl_v, wh_v, res_id;
	logic             wl_en, wh_en, hit, full, jb, ja;
	status_t          res_st;

	assign j_idx  = IDX_W'(pos_q - CNT_W'(1));
	assign p_idx  = pos_q[IDX_W-1:0];
	assign rd_lo  = lo_q[p_idx];
	assign rd_hi  = hi_q[p_idx];
	assign at_end = (pos_q == count_q);
	assign hit    = (pos_q != '0) && (prev_hi_q >= id_q);
	assign full   = (count_q == CNT_W'(MAX_INTERVALS));

	assign need_scan = (cmd_q == CMD_TAKE_ID) || (cmd_q == CMD_GIVE);
	assign scan_stop = at_end || (rd_lo > id_q);
	assign st        = '{need_scan: need_scan, scan_stop: scan_stop};

	// request latch and scan for first entry above the ID
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			id_q  <= id_value;
			pos_q <= '0;
		end else if (ctl.scan) begin
			if (scan_stop) begin
				cur_lo_q <= rd_lo;
				cur_hi_q <= rd_hi;
			end else begin
				prev_lo_q <= rd_lo;
				prev_hi_q <= rd_hi;
				pos_q     <= pos_q + CNT_W'(1);
			end
		end
	end

	// command decision
	always_comb begin
		sh_mode = SH_NONE;
		sh_k    = '0;
		ins_lo  = '0;
		ins_hi  = '0;
		wl_en   = 1'b0;
		wl_k    = '0;
		wl_v    = '0;
		wh_en   = 1'b0;
		wh_k    = '0;
		wh_v    = '0;
		res_id  = id_q;
		res_st  = ST_OK;
		jb      = (pos_q != '0) && (id_q != '0) && (prev_hi_q == id_q - 32'd1);
		ja      = !at_end && (id_q != ID_MAX) && (cur_lo_q == id_q + 32'd1);
		unique case (cmd_q)
			CMD_TAKE_LOW: begin
				if (count_q == '0) begin
					res_id = '0;
					res_st = ST_NOT_FREE;
				end else begin
					res_id = lo_q[0];
					if (lo_q[0] == hi_q[0]) begin
						sh_mode = SH_REMOVE;
					end else begin
						wl_en = 1'b1;
						wl_v  = lo_q[0] + 32'd1;
					end
				end
			end
			CMD_TAKE_ID: begin
				if (!hit) begin
					res_st = ST_NOT_FREE;
				end else if (prev_lo_q == prev_hi_q) begin
					sh_mode = SH_REMOVE;
					sh_k    = j_idx;
				end else if (id_q == prev_lo_q) begin
					wl_en = 1'b1;
					wl_k  = j_idx;
					wl_v  = prev_lo_q + 32'd1;
				end else if (id_q == prev_hi_q) begin
					wh_en = 1'b1;
					wh_k  = j_idx;
					wh_v  = prev_hi_q - 32'd1;
				end else if (full) begin
					res_st = ST_FULL;
				end else begin
					// split the interval around the ID
					wh_en   = 1'b1;
					wh_k    = j_idx;
					wh_v    = id_q - 32'd1;
					sh_mode = SH_INSERT;
					sh_k    = p_idx;
					ins_lo  = id_q + 32'd1;
					ins_hi  = prev_hi_q;
				end
			end
			CMD_GIVE: begin
				if (hit) begin
					res_st = ST_ALREADY_FREE;
				end else if (jb && ja) begin
					wh_en   = 1'b1;
					wh_k    = j_idx;
					wh_v    = cur_hi_q;
					sh_mode = SH_REMOVE;
					sh_k    = p_idx;
				end else if (jb) begin
					wh_en = 1'b1;
					wh_k  = j_idx;
					wh_v  = id_q;
				end else if (ja) begin
					wl_en = 1'b1;
					wl_k  = p_idx;
					wl_v  = id_q;
				end else if (full) begin
					res_st = ST_FULL;
				end else begin
					sh_mode = SH_INSERT;
					sh_k    = p_idx;
					ins_lo  = id_q;
					ins_hi  = id_q;
				end
			end
			default: ;
		endcase
	end

	// table next state: shift, then point writes
	always_comb begin
		count_d = count_q;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			lo_d[i] = lo_q[i];
			hi_d[i] = hi_q[i];
			if (ctl.exec) begin
				if (sh_mode == SH_REMOVE && IDX_W'(i) >= sh_k && i < MAX_INTERVALS - 1) begin
					lo_d[i] = lo_q[(i + 1) % MAX_INTERVALS];
					hi_d[i] = hi_q[(i + 1) % MAX_INTERVALS];
				end else if (sh_mode == SH_INSERT && IDX_W'(i) == sh_k) begin
					lo_d[i] = ins_lo;
					hi_d[i] = ins_hi;
				end else if (sh_mode == SH_INSERT && IDX_W'(i) > sh_k) begin
					lo_d[i] = lo_q[(i + MAX_INTERVALS - 1) % MAX_INTERVALS];
					hi_d[i] = hi_q[(i + MAX_INTERVALS - 1) % MAX_INTERVALS];
				end
				if (wl_en && IDX_W'(i) == wl_k) lo_d[i] = wl_v;
				if (wh_en && IDX_W'(i) == wh_k) hi_d[i] = wh_v;
			end
		end
		if (ctl.exec) begin
			if (sh_mode == SH_REMOVE)      count_d = count_q - CNT_W'(1);
			else if (sh_mode == SH_INSERT) count_d = count_q + CNT_W'(1);
		end
	end

	// new register values on a configuration write
	always_comb begin
		sf_n = start_filled_q;
		rl_n = range_low_q;
		rh_n = range_high_q;
		unique case (cfg_index)
			REG_START_FILLED: sf_n = cfg_data[0];
			REG_RANGE_LOW:    rl_n = cfg_data;
			REG_RANGE_HIGH:   rh_n = cfg_data;
			default: ;
		endcase
	end

	// configuration registers, table and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_filled_q <= 1'b1;
			range_low_q    <= '0;
			range_high_q   <= ID_MAX;
			count_q        <= CNT_W'(1);
			for (int i = 0; i < MAX_INTERVALS; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= (i == 0) ? ID_MAX : '0;
			end
		end else if (cfg_we && cfg_index <= REG_RANGE_HIGH) begin
			start_filled_q <= sf_n;
			range_low_q    <= rl_n;
			range_high_q   <= rh_n;
			lo_q[0]        <= rl_n;
			hi_q[0]        <= rh_n;
			count_q        <= (sf_n && rl_n <= rh_n) ? CNT_W'(1) : '0;
		end else begin
			count_q <= count_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= ctl.exec;
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			id_out <= res_id;
			status <= res_st;
		end
	end

endmodule

// ===== sv/interval_id_allocator.sv =====
// Free ID allocator over 32-bit IDs, held as a sorted table of disjoint
// free intervals (MAX_INTERVALS entries).
// Request channel: command and id_value are taken at a clock edge with
// start high and busy low. Commands: take lowest free ID, take a given ID,
// give an ID back.
// Result channel: done is high for exactly one cycle with id_out and
// status; the receiver cannot stall, so a result is never held.
// Scan: take lowest goes from accept to done without a table scan; take
// given and give back scan the table one entry per cycle, stopping at the
// first entry above the ID or at the end of the table. busy drops with
// done, so a new request can be accepted in the done cycle.
// The scan over the single table read port sets the rate.
// Configuration: cfg_we writes register cfg_index (0 start_filled,
// 1 range_low, 2 range_high) from cfg_data and reloads the table at once.
// Reset: table holds one free interval 0..FFFFFFFF, block idle.
module interval_id_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] id_value,
	output logic        done,
	output logic [31:0] id_out,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ialloc_pkg::*;

	ctrl_t ctl;
	stat_t st;

	ialloc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	ialloc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.command   (command),
		.id_value  (id_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.id_out    (id_out),
		.status    (status)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import ialloc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [31:0] id_value;
	logic        done;
	logic [31:0] id_out;
	logic [1:0]  status;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	typedef struct packed {
		logic [31:0] id;
		logic [1:0]  st;
	} alloc_result_t;

	// predictor copy of the allocator
	logic [31:0] m_filled, m_lo_cfg, m_hi_cfg;
	logic [31:0] free_lo [MAX_INTERVALS];
	logic [31:0] free_hi [MAX_INTERVALS];
	int          free_cnt;

	alloc_result_t pending_results[$];
	int            error_count;

	interval_id_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .id_value(id_value), .done(done), .id_out(id_out),
		.status(status), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	function automatic void reload_table();
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			free_lo[i] = '0;
			free_hi[i] = '0;
		end
		free_cnt = 0;
		if (m_filled[0] && m_lo_cfg <= m_hi_cfg) begin
			free_lo[0] = m_lo_cfg;
			free_hi[0] = m_hi_cfg;
			free_cnt = 1;
		end
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i + 1 < free_cnt; i++) begin
			free_lo[i] = free_lo[i + 1];
			free_hi[i] = free_hi[i + 1];
		end
		free_cnt--;
		free_lo[free_cnt] = '0;
		free_hi[free_cnt] = '0;
	endfunction

	function automatic void add_entry(int p, logic [31:0] lo, logic [31:0] hi);
		for (int i = free_cnt; i > p; i--) begin
			free_lo[i] = free_lo[i - 1];
			free_hi[i] = free_hi[i - 1];
		end
		free_lo[p] = lo;
		free_hi[p] = hi;
		free_cnt++;
	endfunction

	// apply one request to the free list, return its result
	function automatic alloc_result_t apply_request(logic [1:0] cmd, logic [31:0] id);
		alloc_result_t r;
		int p;
		logic below, above;
		r.id = id;
		r.st = ST_OK;
		case (cmd)
			CMD_TAKE_LOW: begin
				if (free_cnt == 0) begin
					r.id = '0;
					r.st = ST_NOT_FREE;
				end else begin
					r.id = free_lo[0];
					if (free_lo[0] == free_hi[0]) drop_entry(0);
					else free_lo[0] = free_lo[0] + 1;
				end
			end
			CMD_TAKE_ID: begin
				r.st = ST_NOT_FREE;
				for (int i = 0; i < free_cnt; i++) begin
					if (id >= free_lo[i] && id <= free_hi[i]) begin
						r.st = ST_OK;
						if (free_lo[i] == free_hi[i]) drop_entry(i);
						else if (id == free_lo[i]) free_lo[i] = id + 1;
						else if (id == free_hi[i]) free_hi[i] = id - 1;
						else if (free_cnt >= MAX_INTERVALS) r.st = ST_FULL;
						else begin
							add_entry(i + 1, id + 1, free_hi[i]);
							free_hi[i] = id - 1;
						end
						break;
					end
				end
			end
			CMD_GIVE: begin
				p = 0;
				while (p < free_cnt && free_lo[p] <= id) p++;
				if (p > 0 && free_hi[p - 1] >= id) r.st = ST_ALREADY_FREE;
				else begin
					below = p > 0 && id != 0 && free_hi[p - 1] == id - 1;
					above = p < free_cnt && id != ID_MAX && free_lo[p] == id + 1;
					if (below && above) begin
						free_hi[p - 1] = free_hi[p];
						drop_entry(p);
					end else if (below) free_hi[p - 1] = id;
					else if (above) free_lo[p] = id;
					else if (free_cnt >= MAX_INTERVALS) r.st = ST_FULL;
					else add_entry(p, id, id);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) report_mismatch("unexpected result", id_out, 0);
			else begin
				e = pending_results.pop_front();
				if (id_out !== e.id) report_mismatch("id_out", id_out, e.id);
				if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
			end
		end
	end

	// send one request, with an occasional gap in front
	int burst_left;
	task automatic send_request(logic [1:0] cmd, logic [31:0] id);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		start    <= 1'b1;
		command  <= cmd;
		id_value <= id;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results = {pending_results, apply_request(cmd, id)};
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_START_FILLED: m_filled = {31'd0, val[0]};
			REG_RANGE_LOW:    m_lo_cfg = val;
			default:          m_hi_cfg = val;
		endcase
		reload_table();
	endtask

	function automatic logic [31:0] rand_id_near(logic [31:0] base, int span);
		return base + $urandom_range(0, span);
	endfunction

	// full range at reset: edges of the ID space, unused command
	task automatic test_full_range();
		send_request(CMD_TAKE_LOW, 32'h1234_5678);
		send_request(CMD_TAKE_LOW, '0);
		send_request(CMD_GIVE, 32'd0);
		send_request(CMD_GIVE, 32'd0);
		send_request(CMD_TAKE_ID, ID_MAX);
		send_request(CMD_TAKE_ID, ID_MAX);
		send_request(CMD_GIVE, ID_MAX);
		send_request(CMD_TAKE_ID, 32'h8000_0000);
		send_request(CMD_GIVE, 32'h8000_0000);
		send_request(2'd3, 32'hA5A5_5A5A);
		drain();
	endtask

	// empty table, single-entry and inverted ranges
	task automatic test_empty_and_small();
		write_reg(REG_START_FILLED, 32'd0);
		send_request(CMD_TAKE_LOW, ID_MAX);
		send_request(CMD_TAKE_ID, 32'd5);
		send_request(CMD_GIVE, 32'd5);
		send_request(CMD_GIVE, 32'd7);
		send_request(CMD_GIVE, 32'd6);
		send_request(CMD_TAKE_LOW, 0);
		drain();
		write_reg(REG_START_FILLED, 32'hFFFF_FFFF);
		write_reg(REG_RANGE_LOW, 32'd100);
		write_reg(REG_RANGE_HIGH, 32'd99);
		send_request(CMD_TAKE_LOW, 0);
		send_request(CMD_GIVE, 32'd100);
		drain();
		write_reg(REG_RANGE_HIGH, 32'd100);
		send_request(CMD_TAKE_LOW, 0);
		send_request(CMD_TAKE_LOW, 0);
		drain();
	endtask

	// fill the table with splits until it reports full
	task automatic test_table_full();
		write_reg(REG_RANGE_LOW, 32'd0);
		write_reg(REG_RANGE_HIGH, 32'd63);
		for (int i = 1; i < 40; i += 2) send_request(CMD_TAKE_ID, i);
		send_request(CMD_GIVE, 32'd1);
		send_request(CMD_TAKE_ID, 32'd2);
		drain();
	endtask

	// random traffic over a small window so merges and splits are frequent
	task automatic test_random(int n);
		logic [31:0] base;
		int span, pick;
		for (int k = 0; k < n; k++) begin
			if (k % 75 == 0) begin
				drain();
				pick = $urandom_range(0, 3);
				base = pick == 0 ? 32'd0 : pick == 1 ? ID_MAX - 60 : $urandom;
				span = $urandom_range(20, 60);
				write_reg(REG_START_FILLED, 32'($urandom_range(0, 4) != 0));
				write_reg(REG_RANGE_LOW, base + $urandom_range(0, 8));
				write_reg(REG_RANGE_HIGH, base + span);
			end
			pick = $urandom_range(0, 9);
			if (pick < 2) send_request(CMD_TAKE_LOW, $urandom);
			else if (pick < 6) send_request(CMD_TAKE_ID, rand_id_near(base, span));
			else if (pick < 9) send_request(CMD_GIVE, rand_id_near(base, span));
			else send_request(2'($urandom_range(0, 3)), $urandom);
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		id_value = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		burst_left = 0;
		m_filled = 32'd1;
		m_lo_cfg = '0;
		m_hi_cfg = ID_MAX;
		reload_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_range();
		test_empty_and_small();
		test_table_full();
		test_random(410);

		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
sv/ialloc_pkg.sv
sv/ialloc_ctrl.sv
sv/ialloc_dp.sv
sv/interval_id_allocator.sv
test/tb_top.sv
